>>> sv/pv_energy_meter_and_diverter_defines.svh
// Assertion macros shared by the checker of the PV energy meter and diverter.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PV_ENERGY_METER_AND_DIVERTER_DEFINES_SVH
`define PV_ENERGY_METER_AND_DIVERTER_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PVEM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvem check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define PVEM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvem check failed");

`endif

>>> sv/pvem_pkg.sv
// Shared types and constants of the PV energy meter and diverter.
// No dependencies; imported by every module of the block but the checker.
package pvem_pkg;

   localparam int unsigned PowerWidth  = 16;
   localparam int unsigned TimeWidth   = 16;
   localparam int unsigned ProdWidth   = PowerWidth + TimeWidth + 1;
   localparam int unsigned EnergyWidth = 64;
   localparam int unsigned AngleWidth  = 8;
   localparam int unsigned PageWidth   = 2;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 16;

   // Configuration register indexes.
   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_LOW_THRESHOLD  = 3'd0,
      CSR_HIGH_THRESHOLD = 3'd1,
      CSR_UPPER_LIMIT    = 3'd2,
      CSR_LOWER_LIMIT    = 3'd3,
      CSR_STEP_SIZE      = 3'd4
   } csr_index_type;

   // Display page codes.
   localparam logic [PageWidth-1:0] PAGE_BLANK    = 2'd0;
   localparam logic [PageWidth-1:0] PAGE_POWERS   = 2'd1;
   localparam logic [PageWidth-1:0] PAGE_ENERGIES = 2'd2;
   localparam logic [PageWidth-1:0] PAGE_WRAP     = 2'd3;

   localparam logic signed [PowerWidth-1:0] RESET_LOW_THRESHOLD  = 16'sd5;
   localparam logic signed [PowerWidth-1:0] RESET_HIGH_THRESHOLD = 16'sd100;
   localparam logic [AngleWidth-1:0]        RESET_UPPER_LIMIT    = 8'd165;
   localparam logic [AngleWidth-1:0]        RESET_LOWER_LIMIT    = 8'd10;
   localparam logic [AngleWidth-1:0]        RESET_STEP_SIZE      = 8'd5;

   typedef struct packed {
      logic signed [PowerWidth-1:0] low_threshold;
      logic signed [PowerWidth-1:0] high_threshold;
      logic [AngleWidth-1:0]        upper_limit;
      logic [AngleWidth-1:0]        lower_limit;
      logic [AngleWidth-1:0]        step_size;
   } servo_cfg_type;

endpackage

>>> sv/pvem_product.sv
// Product stage: power times elapsed time for grid, solar and heater.
// Depends on pvem_pkg.
module pvem_product
   import pvem_pkg::*;
(
   input  logic                         clock,
   input  logic                         load,
   input  logic signed [PowerWidth-1:0] grid_power,
   input  logic signed [PowerWidth-1:0] solar_power,
   input  logic signed [PowerWidth-1:0] heater_power,
   input  logic [TimeWidth-1:0]         elapsed_ms,
   output logic signed [ProdWidth-1:0]  grid_prod,
   output logic signed [ProdWidth-1:0]  solar_prod,
   output logic signed [ProdWidth-1:0]  heater_prod
);

   logic signed [TimeWidth:0]    dt;
   logic signed [ProdWidth-1:0]  grid_prod_in, grid_prod_ff;
   logic signed [ProdWidth-1:0]  solar_prod_in, solar_prod_ff;
   logic signed [ProdWidth-1:0]  heater_prod_in, heater_prod_ff;

   assign dt             = $signed({1'b0, elapsed_ms});
   assign grid_prod_in   = ProdWidth'(grid_power * dt);
   assign solar_prod_in  = ProdWidth'(solar_power * dt);
   assign heater_prod_in = ProdWidth'(heater_power * dt);

   always_ff @(posedge clock) begin
      if (load) begin
         grid_prod_ff   <= grid_prod_in;
         solar_prod_ff  <= solar_prod_in;
         heater_prod_ff <= heater_prod_in;
      end
   end

   assign grid_prod   = grid_prod_ff;
   assign solar_prod  = solar_prod_ff;
   assign heater_prod = heater_prod_ff;

endmodule

>>> sv/pvem_accum.sv
// Four saturating energy accumulators in watt-milliseconds.
// Depends on pvem_pkg.
module pvem_accum
   import pvem_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          grid_negative,
   input  logic signed [ProdWidth-1:0]   grid_prod,
   input  logic signed [ProdWidth-1:0]   solar_prod,
   input  logic signed [ProdWidth-1:0]   heater_prod,
   output logic [EnergyWidth-2:0]        import_energy,
   output logic signed [EnergyWidth-1:0] export_energy,
   output logic signed [EnergyWidth-1:0] solar_energy,
   output logic signed [EnergyWidth-1:0] heater_energy
);

   function automatic logic signed [EnergyWidth-1:0] sat_add(
      input logic signed [EnergyWidth-1:0] total,
      input logic signed [ProdWidth-1:0]   prod
   );
      logic [EnergyWidth:0] sum;
      sum = {total[EnergyWidth-1], total}
          + {{(EnergyWidth+1-ProdWidth){prod[ProdWidth-1]}}, prod};
      // The two top bits differ only when the true sum left the signed range.
      if (sum[EnergyWidth] != sum[EnergyWidth-1]) begin
         return sum[EnergyWidth] ? {1'b1, {(EnergyWidth-1){1'b0}}}
                                 : {1'b0, {(EnergyWidth-1){1'b1}}};
      end
      return sum[EnergyWidth-1:0];
   endfunction

   logic [EnergyWidth-2:0]        import_ff, import_in;
   logic signed [EnergyWidth-1:0] export_ff, export_in;
   logic signed [EnergyWidth-1:0] solar_ff, solar_in;
   logic signed [EnergyWidth-1:0] heater_ff, heater_in;
   logic [EnergyWidth-1:0]        import_sum;

   assign import_sum = {1'b0, import_ff}
                     + {{(EnergyWidth-ProdWidth+2){1'b0}}, grid_prod[ProdWidth-3:0]};

   always_comb begin
      import_in = import_ff;
      export_in = export_ff;
      if (grid_negative) begin
         export_in = sat_add(export_ff, grid_prod);
      end else begin
         import_in = import_sum[EnergyWidth-1] ? '1 : import_sum[EnergyWidth-2:0];
      end
      solar_in  = sat_add(solar_ff, solar_prod);
      heater_in = sat_add(heater_ff, heater_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         import_ff <= '0;
         export_ff <= '0;
         solar_ff  <= '0;
         heater_ff <= '0;
      end else if (advance) begin
         import_ff <= import_in;
         export_ff <= export_in;
         solar_ff  <= solar_in;
         heater_ff <= heater_in;
      end
   end

   assign import_energy = import_ff;
   assign export_energy = export_ff;
   assign solar_energy  = solar_ff;
   assign heater_energy = heater_ff;

endmodule

>>> sv/pvem_ctrl.sv
// Servo stepping and display page counter.
// Depends on pvem_pkg.
module pvem_ctrl
   import pvem_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic signed [PowerWidth-1:0] grid_power,
   input  logic                         button_pressed,
   input  servo_cfg_type                cfg,
   output logic [AngleWidth-1:0]        servo_angle,
   output logic                         servo_moved,
   output logic [PageWidth-1:0]         page_shown
);

   logic [AngleWidth-1:0] angle_ff, angle_in;
   logic                  moved_ff, moved_in;
   logic [PageWidth-1:0]  count_ff, count_in;
   logic [PageWidth-1:0]  page_ff, page_in;
   logic [AngleWidth:0]   up_sum;
   logic [AngleWidth-1:0] after_up;
   logic [PageWidth-1:0]  count_next;

   assign up_sum = {1'b0, angle_ff} + {1'b0, cfg.step_size};

   always_comb begin
      after_up = angle_ff;
      if (grid_power <= cfg.low_threshold && angle_ff < cfg.upper_limit) begin
         after_up = up_sum[AngleWidth] ? '1 : up_sum[AngleWidth-1:0];
      end
      // The step down is tested against the angle after any step up.
      angle_in = after_up;
      if (grid_power >= cfg.high_threshold && after_up > cfg.lower_limit) begin
         angle_in = (after_up > cfg.step_size) ? after_up - cfg.step_size : '0;
      end
      moved_in = (angle_in != angle_ff);
   end

   always_comb begin
      count_next = button_pressed ? count_ff + 1'b1 : count_ff;
      count_in   = count_next;
      page_in    = count_next;
      if (count_next == PAGE_WRAP || count_next == PAGE_BLANK) begin
         page_in  = PAGE_BLANK;
         count_in = PAGE_POWERS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= '0;
         count_ff <= PAGE_POWERS;
      end else if (advance) begin
         angle_ff <= angle_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         moved_ff <= moved_in;
         page_ff  <= page_in;
      end
   end

   assign servo_angle = angle_ff;
   assign servo_moved = moved_ff;
   assign page_shown  = page_ff;

endmodule

>>> sv/pv_energy_meter_and_diverter.sv
// Top level of the PV energy meter and surplus diverter.
// Depends on pvem_pkg, pvem_product, pvem_accum and pvem_ctrl.
//
//   port group   direction  payload
//   req_*        in         measurement: powers, elapsed time, page button
//   rsp_*        out        split powers, four energy totals, servo, page
//   csr_*        in         threshold and servo limit writes, no read-back
//
// Three register stages: input register, product register, result register.
// One measurement is accepted per cycle unless a stall holds the pipe; its
// result passes through the product register and then the result register.
// Sync reset clears totals, servo angle and valids, and sets page counter to 1.
// A stalled result holds the pipe; stages behind it keep filling until full.
module pv_energy_meter_and_diverter
   import pvem_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // grid_power[15:0], solar_power[31:16], heater_power[47:32],
   // elapsed_ms[63:48], button_pressed[64], zero fill to 72 bits
   input  logic [71:0]             req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // import_power[14:0], export_power[30:15], import_energy[93:31],
   // export_energy[157:94], solar_energy[221:158], heater_energy[285:222],
   // servo_angle[293:286], servo_moved[294], page_shown[296:295], zero fill
   output logic [303:0]            rsp_tdata,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   servo_cfg_type cfg_ff;

   logic                         s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic                         s1_ready, s2_ready, out_ready;
   logic                         s1_load, s2_load, out_load;
   logic signed [PowerWidth-1:0] grid_s1_ff, solar_s1_ff, heater_s1_ff;
   logic [TimeWidth-1:0]         dt_s1_ff;
   logic                         button_s1_ff;
   logic signed [PowerWidth-1:0] grid_s2_ff;
   logic                         button_s2_ff;
   logic signed [ProdWidth-1:0]  grid_prod, solar_prod, heater_prod;
   logic [PowerWidth-2:0]        import_power_ff, import_power_in;
   logic signed [PowerWidth-1:0] export_power_ff, export_power_in;
   logic [EnergyWidth-2:0]       import_energy;
   logic signed [EnergyWidth-1:0] export_energy, solar_energy, heater_energy;
   logic [AngleWidth-1:0]        servo_angle;
   logic                         servo_moved;
   logic [PageWidth-1:0]         page_shown;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold  <= RESET_LOW_THRESHOLD;
         cfg_ff.high_threshold <= RESET_HIGH_THRESHOLD;
         cfg_ff.upper_limit    <= RESET_UPPER_LIMIT;
         cfg_ff.lower_limit    <= RESET_LOWER_LIMIT;
         cfg_ff.step_size      <= RESET_STEP_SIZE;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LOW_THRESHOLD:  cfg_ff.low_threshold  <= $signed(csr_wdata);
            CSR_HIGH_THRESHOLD: cfg_ff.high_threshold <= $signed(csr_wdata);
            CSR_UPPER_LIMIT:    cfg_ff.upper_limit    <= csr_wdata[AngleWidth-1:0];
            CSR_LOWER_LIMIT:    cfg_ff.lower_limit    <= csr_wdata[AngleWidth-1:0];
            CSR_STEP_SIZE:      cfg_ff.step_size      <= csr_wdata[AngleWidth-1:0];
            default: ;
         endcase
      end
   end

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign s1_load    = req_tvalid && s1_ready;
   assign s2_load    = s1_valid_ff && s2_ready;
   assign out_load   = s2_valid_ff && out_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         grid_s1_ff   <= $signed(req_tdata[15:0]);
         solar_s1_ff  <= $signed(req_tdata[31:16]);
         heater_s1_ff <= $signed(req_tdata[47:32]);
         dt_s1_ff     <= req_tdata[63:48];
         button_s1_ff <= req_tdata[64];
      end
      if (s2_load) begin
         grid_s2_ff   <= grid_s1_ff;
         button_s2_ff <= button_s1_ff;
      end
      if (out_load) begin
         import_power_ff <= import_power_in;
         export_power_ff <= export_power_in;
      end
   end

   assign import_power_in = grid_s2_ff[PowerWidth-1] ? '0 : grid_s2_ff[PowerWidth-2:0];
   assign export_power_in = grid_s2_ff[PowerWidth-1] ? grid_s2_ff : '0;

   pvem_product u_product (
      .clock        (clock),
      .load         (s2_load),
      .grid_power   (grid_s1_ff),
      .solar_power  (solar_s1_ff),
      .heater_power (heater_s1_ff),
      .elapsed_ms   (dt_s1_ff),
      .grid_prod    (grid_prod),
      .solar_prod   (solar_prod),
      .heater_prod  (heater_prod)
   );

   pvem_accum u_accum (
      .clock         (clock),
      .reset         (reset),
      .advance       (out_load),
      .grid_negative (grid_s2_ff[PowerWidth-1]),
      .grid_prod     (grid_prod),
      .solar_prod    (solar_prod),
      .heater_prod   (heater_prod),
      .import_energy (import_energy),
      .export_energy (export_energy),
      .solar_energy  (solar_energy),
      .heater_energy (heater_energy)
   );

   pvem_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .advance        (out_load),
      .grid_power     (grid_s2_ff),
      .button_pressed (button_s2_ff),
      .cfg            (cfg_ff),
      .servo_angle    (servo_angle),
      .servo_moved    (servo_moved),
      .page_shown     (page_shown)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, page_shown, servo_moved, servo_angle, heater_energy,
                        solar_energy, export_energy, import_energy, export_power_ff,
                        import_power_ff};

endmodule

>>> sv/pvem_checker.sv
// Port-level checks for the PV energy meter and diverter, with its bind.
// Depends on pv_energy_meter_and_diverter_defines.svh.
`include "pv_energy_meter_and_diverter_defines.svh"

module pvem_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [303:0] rsp_tdata
);

   // A stalled result beat keeps its payload.
   `PVEM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Import and export power are never both non-zero.
   `PVEM_ASSERT_NOW(a_power_split, clock, reset, rsp_tvalid, rsp_tdata[14:0] == 15'd0 || rsp_tdata[30:15] == 16'd0)

   // The export total never goes positive.
   `PVEM_ASSERT_NOW(a_export_sign, clock, reset, rsp_tvalid, rsp_tdata[157] || rsp_tdata[157:94] == 64'd0)

   // The page counter wraps before it would show a fourth page.
   `PVEM_ASSERT_NOW(a_page_range, clock, reset, rsp_tvalid, rsp_tdata[296:295] != 2'd3)

   // The import total only grows from one result to the next.
   `PVEM_ASSERT_NEXT(a_import_grows, clock, reset, rsp_tvalid && rsp_tready, !rsp_tvalid || rsp_tdata[93:31] >= $past(rsp_tdata[93:31]))

endmodule

bind pv_energy_meter_and_diverter pvem_checker u_pvem_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
